FILE: design/can_bts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CAN bit timing search - shared definitions
// Field widths, reset value of the clock register and quanta limits.
// ----------------------------------------------------------------------------
package can_bts_pkg;

  // Port field widths
  localparam int unsigned CLK_W   = 32;
  localparam int unsigned RATE_W  = 32;
  localparam int unsigned PRESC_W = 11;
  localparam int unsigned SEG1_W  = 9;
  localparam int unsigned SEG2_W  = 8;
  localparam int unsigned SJW_W   = 3;

  // Clock register value after reset (80 MHz)
  localparam logic [CLK_W-1:0] CLOCK_HZ_RST = CLK_W'(80000000);

  // Quanta per bit must lie in 3..385; with seg1 = 3/4 of (quanta - 1)
  // capped at 256 and seg2 capped at 128, the usable top is 343.
  localparam logic [CLK_W-1:0] QUANTA_MIN = CLK_W'(3);
  localparam logic [CLK_W-1:0] QUANTA_LIM = CLK_W'(343);

  // Bits of the quanta count once it is known to be in range
  localparam int unsigned QNT_W = 9;

  // Synchronization jump width ceiling
  localparam logic [SJW_W-1:0] SJW_MAX = SJW_W'(4);

endpackage : can_bts_pkg
`default_nettype wire

FILE: design/can_bit_timing_search.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CAN bit timing search
// Finds the first prescaler whose bit timing hits the requested rate exactly.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Fields
//  command   in         start_i & !busy_o         bitrate_i
//  result    out        done_o (one-cycle strobe) found_o, prescaler_o,
//                                                 phase_seg1_o, phase_seg2_o,
//                                                 jump_width_o
//  config    in         clock_hz_we_i             clock_hz_i
//
//  Zero bitrate: result strobe in the cycle after the transfer.
//  Otherwise each prescaler candidate runs a restoring divider over the
//  32 dividend bits, one bit per cycle, then one evaluation state; the
//  search stops once the quotient drops below 3, at the last prescaler
//  or on the first exact match.
//  Reset (rst_ni low, async) returns to idle and loads 80 MHz into clock_hz.
//  The result cannot be stalled; busy_o is low in the strobe cycle, so a new
//  command may transfer at that same edge.
// ----------------------------------------------------------------------------
module can_bit_timing_search #(
  parameter int unsigned MAX_PRESCALER = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration
  input  logic                             clock_hz_we_i,
  input  logic [can_bts_pkg::CLK_W-1:0]    clock_hz_i,
  // command
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic [can_bts_pkg::RATE_W-1:0]   bitrate_i,
  // result
  output logic                             done_o,
  output logic                             found_o,
  output logic [can_bts_pkg::PRESC_W-1:0]  prescaler_o,
  output logic [can_bts_pkg::SEG1_W-1:0]   phase_seg1_o,
  output logic [can_bts_pkg::SEG2_W-1:0]   phase_seg2_o,
  output logic [can_bts_pkg::SJW_W-1:0]    jump_width_o
);
  import can_bts_pkg::*;

  // Prescaler counter width and divisor / remainder width
  localparam int unsigned PW  = $clog2(MAX_PRESCALER + 1);
  localparam int unsigned DW  = RATE_W + PW;
  localparam int unsigned CW  = $clog2(CLK_W);
  localparam int unsigned MW  = PW + QNT_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_EVAL
  } state_e;

  state_e              state_q;
  logic [CLK_W-1:0]    clock_hz_q;
  logic [RATE_W-1:0]   rate_q;
  logic [PW-1:0]       presc_q;
  logic [DW-1:0]       div_q;    // rate * prescaler
  logic [DW-1:0]       rem_q;
  logic [DW-1:0]       rem_d;
  logic [CLK_W-1:0]    dvd_q;    // dividend, shifted out MSB first
  logic [CLK_W-1:0]    quo_q;
  logic [CW-1:0]       cnt_q;
  logic                busy_q;
  logic                done_q;
  logic                found_q;
  logic [PRESC_W-1:0]  presc_out_q;
  logic [SEG1_W-1:0]   seg1_q;
  logic [SEG2_W-1:0]   seg2_q;
  logic [SJW_W-1:0]    sjw_q;

  // Restoring divider step: bring in one dividend bit, subtract if it fits
  logic [DW:0] rem_sh;
  logic [DW:0] rem_sub;
  logic        q_bit;

  always_comb begin
    rem_sh  = {rem_q, dvd_q[CLK_W-1]};
    rem_sub = rem_sh - {1'b0, div_q};
    q_bit   = (rem_sh >= {1'b0, div_q});
    rem_d   = q_bit ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
  end

  // Candidate check: quanta in range and clock / (p * quanta) == rate,
  // which holds exactly when the remainder is below p * quanta
  logic               q_ok;
  logic               q_low;
  logic [QNT_W-1:0]   quanta;
  logic [MW-1:0]      pq_prod;
  logic               exact;
  logic               last_p;
  logic [QNT_W-1:0]   rest;
  logic [QNT_W+1:0]   rest3;
  logic [SEG1_W-1:0]  seg1;
  logic [QNT_W-1:0]   seg2_w;
  logic [SEG2_W-1:0]  seg2;
  logic [SJW_W-1:0]   sjw;

  always_comb begin
    q_low   = (quo_q < QUANTA_MIN);
    q_ok    = !q_low && (quo_q <= QUANTA_LIM);
    quanta  = quo_q[QNT_W-1:0];
    pq_prod = MW'(presc_q) * MW'(quanta);
    exact   = (rem_q < {{(DW-MW){1'b0}}, pq_prod});
    last_p  = (presc_q == PW'(MAX_PRESCALER));
    rest    = quanta - QNT_W'(1);
    rest3   = {1'b0, rest, 1'b0} + {2'b00, rest};
    seg1    = rest3[QNT_W+1:2];
    seg2_w  = rest - seg1;
    seg2    = seg2_w[SEG2_W-1:0];
    sjw     = (seg2 < SEG2_W'(SJW_MAX)) ? seg2[SJW_W-1:0] : SJW_MAX;
  end

  // Sequencer, datapath and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      clock_hz_q  <= CLOCK_HZ_RST;
      busy_q      <= 1'b0;
      done_q      <= 1'b0;
      found_q     <= 1'b0;
      presc_out_q <= '0;
      seg1_q      <= '0;
      seg2_q      <= '0;
      sjw_q       <= '0;
      rate_q      <= '0;
      presc_q     <= '0;
      div_q       <= '0;
      rem_q       <= '0;
      dvd_q       <= '0;
      quo_q       <= '0;
      cnt_q       <= '0;
    end else begin
      done_q <= 1'b0;
      if (clock_hz_we_i) begin
        clock_hz_q <= clock_hz_i;
      end
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            if (bitrate_i == '0) begin
              // invalid rate: report not found right away
              done_q      <= 1'b1;
              found_q     <= 1'b0;
              presc_out_q <= '0;
              seg1_q      <= '0;
              seg2_q      <= '0;
              sjw_q       <= '0;
            end else begin
              busy_q  <= 1'b1;
              rate_q  <= bitrate_i;
              presc_q <= PW'(1);
              div_q   <= DW'(bitrate_i);
              rem_q   <= '0;
              dvd_q   <= clock_hz_q;
              cnt_q   <= CW'(CLK_W - 1);
              state_q <= S_DIV;
            end
          end
        end
        S_DIV: begin
          rem_q <= rem_d;
          dvd_q <= {dvd_q[CLK_W-2:0], 1'b0};
          quo_q <= {quo_q[CLK_W-2:0], q_bit};
          cnt_q <= cnt_q - CW'(1);
          if (cnt_q == '0) begin
            state_q <= S_EVAL;
          end
        end
        S_EVAL: begin
          priority if (q_ok && exact) begin
            done_q      <= 1'b1;
            busy_q      <= 1'b0;
            found_q     <= 1'b1;
            presc_out_q <= PRESC_W'(presc_q);
            seg1_q      <= seg1;
            seg2_q      <= seg2;
            sjw_q       <= sjw;
            state_q     <= S_IDLE;
          end else if (q_low || last_p) begin
            // quotient too small (it only shrinks with larger prescalers) or last prescaler tried: give up
            done_q      <= 1'b1;
            busy_q      <= 1'b0;
            found_q     <= 1'b0;
            presc_out_q <= '0;
            seg1_q      <= '0;
            seg2_q      <= '0;
            sjw_q       <= '0;
            state_q     <= S_IDLE;
          end else begin
            presc_q <= presc_q + PW'(1);
            div_q   <= div_q + DW'(rate_q);
            rem_q   <= '0;
            dvd_q   <= clock_hz_q;
            cnt_q   <= CW'(CLK_W - 1);
            state_q <= S_DIV;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o       = busy_q;
  assign done_o       = done_q;
  assign found_o      = found_q;
  assign prescaler_o  = presc_out_q;
  assign phase_seg1_o = seg1_q;
  assign phase_seg2_o = seg2_q;
  assign jump_width_o = sjw_q;

endmodule : can_bit_timing_search
`default_nettype wire

FILE: design/can_bts_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CAN bit timing search - port checker
// Watches command and result ports for sequencing and result consistency.
// ----------------------------------------------------------------------------
module can_bts_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             start_i,
  input logic                             busy_o,
  input logic                             done_o,
  input logic                             found_o,
  input logic [can_bts_pkg::PRESC_W-1:0]  prescaler_o,
  input logic [can_bts_pkg::SEG1_W-1:0]   phase_seg1_o,
  input logic [can_bts_pkg::SEG2_W-1:0]   phase_seg2_o,
  input logic [can_bts_pkg::SJW_W-1:0]    jump_width_o
);
  import can_bts_pkg::*;

  // a transfer either starts a search or answers on the next cycle
  a_start_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o || done_o)
    else $error("transfer neither started a search nor produced a result");

  // a search ends only with a result
  a_busy_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> busy_o || done_o)
    else $error("search ended without a result");

  // result strobe marks the end of a search
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while still busy");

  // a miss reports all-zero timing
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !found_o |-> prescaler_o == '0 && phase_seg1_o == '0 &&
                           phase_seg2_o == '0 && jump_width_o == '0)
    else $error("timing fields not zero on a miss");

  // a hit has a nonzero prescaler, nonzero segments and a nonzero jump width bounded by SJW_MAX
  a_hit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && found_o |-> prescaler_o != '0 && phase_seg1_o != '0 &&
                          phase_seg2_o != '0 && jump_width_o != '0 &&
                          jump_width_o <= SJW_MAX)
    else $error("inconsistent timing on a hit");

endmodule : can_bts_checker

bind can_bit_timing_search can_bts_checker u_can_bts_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_o       (busy_o),
  .done_o       (done_o),
  .found_o      (found_o),
  .prescaler_o  (prescaler_o),
  .phase_seg1_o (phase_seg1_o),
  .phase_seg2_o (phase_seg2_o),
  .jump_width_o (jump_width_o)
);
`default_nettype wire

FILE: verif/tb_can_bit_timing_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the CAN bit timing search
// Sends bitrate commands under several clock register settings and checks
// every result against a local model of the prescaler search.
// ----------------------------------------------------------------------------
module tb_can_bit_timing_search;
  import can_bts_pkg::*;

  localparam int unsigned MAX_PRESC    = 1024;
  // search limits on quanta and on the two time segments
  localparam longint unsigned QNT_LO   = 3;
  localparam longint unsigned QNT_HI   = 385;
  localparam longint unsigned SEG1_TOP = 256;
  localparam longint unsigned SEG2_TOP = 128;
  // idle cycles let pass after the last result before a register write
  localparam int unsigned SETTLE_CYCLES = 8;
  // watchdog limit on quiet cycles, above the longest correct item
  localparam int unsigned STALL_LIMIT   = 200000;

  typedef struct packed {
    logic              found;
    logic [PRESC_W-1:0] prescaler;
    logic [SEG1_W-1:0]  seg1;
    logic [SEG2_W-1:0]  seg2;
    logic [SJW_W-1:0]   sjw;
  } timing_t;

  logic               clk_i;
  logic               rst_ni;
  logic               clock_hz_we_i;
  logic [CLK_W-1:0]   clock_hz_i;
  logic               start_i;
  logic               busy_o;
  logic [RATE_W-1:0]  bitrate_i;
  logic               done_o;
  logic               found_o;
  logic [PRESC_W-1:0] prescaler_o;
  logic [SEG1_W-1:0]  phase_seg1_o;
  logic [SEG2_W-1:0]  phase_seg2_o;
  logic [SJW_W-1:0]   jump_width_o;

  // model copy of the clock register and the timings still to come
  logic [CLK_W-1:0]  model_clock_hz;
  timing_t           expected_timings[$];
  logic [RATE_W-1:0] rate_list[$];

  int unsigned mismatches;
  int unsigned commands_sent;
  int unsigned results_checked;
  int unsigned timings_found;
  int unsigned clock_writes;
  int unsigned quiet_cycles;

  can_bit_timing_search #(
    .MAX_PRESCALER (MAX_PRESC)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .clock_hz_we_i (clock_hz_we_i),
    .clock_hz_i    (clock_hz_i),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .bitrate_i     (bitrate_i),
    .done_o        (done_o),
    .found_o       (found_o),
    .prescaler_o   (prescaler_o),
    .phase_seg1_o  (phase_seg1_o),
    .phase_seg2_o  (phase_seg2_o),
    .jump_width_o  (jump_width_o)
  );

  // 2 ns clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Prescaler search: first candidate whose rebuilt rate is exact wins
  function automatic timing_t search_bit_timing(input logic [RATE_W-1:0] rate,
                                                input logic [CLK_W-1:0] hz);
    timing_t res;
    logic [63:0] quanta;
    logic [63:0] rest;
    logic [63:0] s1;
    logic [63:0] s2;
    logic [63:0] rebuilt;
    res = '0;
    if (rate == '0) return res;
    for (int p = 1; p <= MAX_PRESC; p++) begin
      // products kept at full width, no 32-bit wrap
      quanta = 64'(hz) / (64'(rate) * 64'(p));
      if (quanta < QNT_LO || quanta > QNT_HI) continue;
      rest = quanta - 64'd1;
      s1   = (rest * 64'd3) / 64'd4;
      s2   = rest - s1;
      if (s1 < 64'd1 || s1 > SEG1_TOP) continue;
      if (s2 < 64'd1 || s2 > SEG2_TOP) continue;
      rebuilt = 64'(hz) / (64'(p) * (64'd1 + s1 + s2));
      if (rebuilt != 64'(rate)) continue;
      res.found     = 1'b1;
      res.prescaler = PRESC_W'(p);
      res.seg1      = SEG1_W'(s1);
      res.seg2      = SEG2_W'(s2);
      res.sjw       = (s2 < 64'(SJW_MAX)) ? SJW_W'(s2) : SJW_MAX;
      return res;
    end
    return res;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  task automatic compare_timing(input timing_t want, input timing_t seen);
    if (seen.found !== want.found)
      note_mismatch($sformatf("found exp %0d got %0d", want.found, seen.found));
    if (seen.prescaler !== want.prescaler)
      note_mismatch($sformatf("prescaler exp %0d got %0d", want.prescaler,
                              seen.prescaler));
    if (seen.seg1 !== want.seg1)
      note_mismatch($sformatf("phase_seg1 exp %0d got %0d", want.seg1, seen.seg1));
    if (seen.seg2 !== want.seg2)
      note_mismatch($sformatf("phase_seg2 exp %0d got %0d", want.seg2, seen.seg2));
    if (seen.sjw !== want.sjw)
      note_mismatch($sformatf("jump_width exp %0d got %0d", want.sjw, seen.sjw));
  endtask

  // Result check, register tracking and command prediction at each edge
  always @(posedge clk_i) begin : result_check
    timing_t seen;
    timing_t want;
    if (rst_ni) begin
      quiet_cycles++;
      if (clock_hz_we_i) begin
        model_clock_hz = clock_hz_i;
        clock_writes++;
        quiet_cycles = 0;
      end
      if (done_o) begin
        quiet_cycles = 0;
        seen = {found_o, prescaler_o, phase_seg1_o, phase_seg2_o, jump_width_o};
        if (expected_timings.size() == 0) begin
          note_mismatch("result strobe with no command outstanding");
        end else begin
          want = expected_timings.pop_front();
          compare_timing(want, seen);
          results_checked++;
          if (want.found) timings_found++;
        end
      end
      if (start_i && !busy_o) begin
        quiet_cycles = 0;
        commands_sent++;
        expected_timings.push_back(search_bit_timing(bitrate_i, model_clock_hz));
      end
    end
  end

  // Watchdog: ends the run when nothing transfers for too long
  initial begin : watchdog
    while (quiet_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("can_bit_timing_search test failed");
    $finish;
  end

  // One command transfer; start stays high for a back-to-back follower
  task automatic send_bitrate(input logic [RATE_W-1:0] rate);
    @(negedge clk_i);
    start_i   <= 1'b1;
    bitrate_i <= rate;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // Send the queued rates in bursts with random gaps
  task automatic drive_rate_list();
    int burst;
    int gap;
    while (rate_list.size() > 0) begin
      burst = ($urandom_range(0, 4) == 0) ? 24 : $urandom_range(1, 6);
      while (burst > 0 && rate_list.size() > 0) begin
        send_bitrate(rate_list.pop_front());
        burst--;
      end
      gap = $urandom_range(0, 5);
      repeat (gap) begin
        @(negedge clk_i);
        start_i <= 1'b0;
      end
    end
    @(negedge clk_i);
    start_i <= 1'b0;
  endtask

  // Hold off until every outstanding result has come back
  task automatic wait_drained();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (expected_timings.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_clock(input logic [CLK_W-1:0] hz);
    wait_drained();
    @(negedge clk_i);
    clock_hz_we_i <= 1'b1;
    clock_hz_i    <= hz;
    @(negedge clk_i);
    clock_hz_we_i <= 1'b0;
  endtask

  // Mostly rates built from a prescaler and quanta count, plus some noise
  function automatic logic [RATE_W-1:0] pick_rate(input logic [CLK_W-1:0] hz);
    int unsigned sel;
    longint unsigned p;
    longint unsigned q;
    longint unsigned rate;
    sel = $urandom_range(0, 99);
    p   = ($urandom_range(0, 19) == 0) ? $urandom_range(1, MAX_PRESC)
                                       : $urandom_range(1, 32);
    if (sel < 70) begin
      q = ($urandom_range(0, 9) == 0) ? $urandom_range(344, 400)
                                      : $urandom_range(3, 343);
      rate = longint'(hz) / (p * q);
    end else if (sel < 80) begin
      // just off an exact rate; small quanta keep the search short
      q    = $urandom_range(3, 40);
      rate = longint'(hz) / ($urandom_range(1, 32) * q);
      rate = $urandom_range(0, 1) ? rate + 1 : rate - 1;
    end else if (sel < 95) begin
      rate = $urandom;
    end else begin
      rate = 0;
    end
    return RATE_W'(rate);
  endfunction

  // Reset clock value: edges of the rate, quanta limits, short segment two
  task automatic test_reset_clock_corners();
    rate_list = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd80000000, 32'd26666666,
                  32'd233236, 32'd232558, 32'd500000, 32'd1000000, 32'd125000,
                  32'd16000000, 32'd8888888, 32'd6153846, 32'd4705882,
                  32'h5555_5555, 32'hAAAA_AAAA, 32'd33333};
    drive_rate_list();
  endtask

  // Clock chosen so only the largest prescaler fits
  task automatic test_largest_prescaler();
    write_clock(32'd352000);
    rate_list = '{32'd1};
    drive_rate_list();
  endtask

  // Zero and one hertz clocks never give a timing
  task automatic test_degenerate_clocks();
    write_clock(32'd0);
    rate_list = '{32'd0, 32'd1, 32'd500000};
    drive_rate_list();
    write_clock(32'd1);
    rate_list = '{32'd1, 32'hFFFF_FFFF};
    drive_rate_list();
  endtask

  // Full-scale clock: wide products and a search that runs out
  task automatic test_full_scale_clock();
    write_clock(32'hFFFF_FFFF);
    rate_list = '{32'd1, 32'hFFFF_FFFF, 32'd1431655765};
    drive_rate_list();
  endtask

  // Random rates under a handful of clock settings
  task automatic test_random_rates();
    logic [CLK_W-1:0] clocks[5];
    clocks = '{32'd80000000, 32'd40000000, 32'hFFFF_FFFF, 32'd24000000,
               32'($urandom)};
    foreach (clocks[c]) begin
      write_clock(clocks[c]);
      repeat (20) rate_list.push_back(pick_rate(clocks[c]));
      drive_rate_list();
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    clock_hz_we_i   = 1'b0;
    clock_hz_i      = '0;
    start_i         = 1'b0;
    bitrate_i       = '0;
    model_clock_hz  = CLOCK_HZ_RST;
    mismatches      = 0;
    commands_sent   = 0;
    results_checked = 0;
    timings_found   = 0;
    clock_writes    = 0;
    quiet_cycles    = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_clock_corners();
    test_largest_prescaler();
    test_degenerate_clocks();
    test_full_scale_clock();
    test_random_rates();

    wait_drained();
    repeat (40) @(posedge clk_i);
    $display("Covered %0d bitrate commands, %0d results checked, %0d exact timings.",
             commands_sent, results_checked, timings_found);
    $display("Clock register written %0d times; %0d mismatches seen.",
             clock_writes, mismatches);
    if (mismatches == 0 && expected_timings.size() == 0) begin
      $display("can_bit_timing_search test passed");
    end else begin
      $display("can_bit_timing_search test failed");
    end
    $finish;
  end

endmodule
